FILE: hw/rtl/phmn_pkg.sv
// ----------------------------------------------------------------------------
// phmn_pkg
// Shared types and constants for the piezo hit to MIDI note block.
// ----------------------------------------------------------------------------
package phmn_pkg;

  localparam int SAMPLE_W = 12;
  localparam int VEL_W    = 7;
  localparam int WIN_W    = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 12;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_VEL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VEL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW     = 3'd4;

  // MIDI message bytes, in send order
  localparam logic [2:0] BYTE_STATUS_OFF = 3'd0;
  localparam logic [2:0] BYTE_NOTE_OFF   = 3'd1;
  localparam logic [2:0] BYTE_VEL_OFF    = 3'd2;
  localparam logic [2:0] BYTE_STATUS_ON  = 3'd3;
  localparam logic [2:0] BYTE_NOTE_ON    = 3'd4;
  localparam logic [2:0] BYTE_VEL_ON     = 3'd5;

  localparam logic [7:0] NOTE_ON_STATUS = 8'h90;
  localparam logic [7:0] OFF_VELOCITY   = 8'h00;

  // velocity divider: 22-bit dividend, one quotient bit per cycle
  localparam int DIV_STEPS = 22;
  localparam int DIV_CNT_W = 5;

  localparam int NOTE_TABLE_LEN = 17;
  localparam logic [7:0] DRUM_NOTES [NOTE_TABLE_LEN] = '{
    8'd36, 8'd38, 8'd37, 8'd42, 8'd44, 8'd46, 8'd65, 8'd48, 8'd45,
    8'd41, 8'd51, 8'd53, 8'd49, 8'd57, 8'd58, 8'd52, 8'd55
  };

  typedef struct packed {
    logic       start_cap;  // trigger beat: clear peak and window count
    logic       peak_step;  // capture beat: track peak, advance count
    logic       note_step;  // idle beat without trigger: apply presses
    logic       mul_go;
    logic       div_load;
    logic       div_step;
    logic       vel_latch;
    logic [2:0] byte_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic trigger;
    logic window_done;
    logic div_last;
  } dp_stat_t;

  // index is below 32, so one conditional subtract gives the remainder
  function automatic logic [7:0] note_lookup(input logic [4:0] idx);
    logic [4:0] red;
    red = (idx >= 5'(NOTE_TABLE_LEN)) ? idx - 5'(NOTE_TABLE_LEN) : idx;
    return DRUM_NOTES[red];
  endfunction

endpackage

FILE: hw/rtl/phmn_ctrl.sv
// ----------------------------------------------------------------------------
// phmn_ctrl
// Sequencer: capture window, velocity computation, and six-byte send.
// ----------------------------------------------------------------------------
module phmn_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic                 m_tlast,
  input  phmn_pkg::dp_stat_t   stat,
  output phmn_pkg::ctrl_cmd_t  cmd
);
  import phmn_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CAP  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_LOAD = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_VEL  = 3'd5;
  localparam logic [2:0] ST_SEND = 3'd6;

  logic [2:0] state, state_next;
  logic [2:0] byte_cnt, byte_cnt_next;
  logic       in_beat, out_beat;

  assign s_tready = (state == ST_IDLE) || (state == ST_CAP);
  assign in_beat  = s_tvalid && s_tready;
  assign m_tvalid = (state == ST_SEND);
  assign out_beat = m_tvalid && m_tready;
  assign m_tlast  = m_tvalid && (byte_cnt == BYTE_VEL_ON);

  always_comb begin
    cmd           = '0;
    cmd.byte_sel  = byte_cnt;
    cmd.start_cap = (state == ST_IDLE) && in_beat && stat.trigger;
    cmd.note_step = (state == ST_IDLE) && in_beat && !stat.trigger;
    cmd.peak_step = (state == ST_CAP) && in_beat;
    cmd.mul_go    = (state == ST_MUL);
    cmd.div_load  = (state == ST_LOAD);
    cmd.div_step  = (state == ST_DIV);
    cmd.vel_latch = (state == ST_VEL);
  end

  always_comb begin
    state_next    = state;
    byte_cnt_next = byte_cnt;
    case (state)
      ST_IDLE: begin
        if (in_beat && stat.trigger) state_next = ST_CAP;
      end
      ST_CAP: begin
        if (in_beat && stat.window_done) state_next = ST_MUL;
      end
      ST_MUL:  state_next = ST_LOAD;
      ST_LOAD: state_next = ST_DIV;
      ST_DIV: begin
        if (stat.div_last) state_next = ST_VEL;
      end
      ST_VEL: begin
        state_next    = ST_SEND;
        byte_cnt_next = BYTE_STATUS_OFF;
      end
      ST_SEND: begin
        if (out_beat) begin
          if (byte_cnt == BYTE_VEL_ON) begin
            state_next = ST_IDLE;
          end else begin
            byte_cnt_next = byte_cnt + 3'd1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      byte_cnt <= BYTE_STATUS_OFF;
    end else begin
      state    <= state_next;
      byte_cnt <= byte_cnt_next;
    end
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input accepted while message bytes pending");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_beat && m_tlast) |=> s_tready)
    else $error("block not ready after last byte");

  a_vel_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_VEL) |-> $past(stat.div_last))
    else $error("velocity latched before divider finished");

  a_send_from_vel: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> (byte_cnt == BYTE_STATUS_OFF))
    else $error("message does not start at status byte");
`endif

endmodule

FILE: hw/rtl/phmn_dp.sv
// ----------------------------------------------------------------------------
// phmn_dp
// Datapath: config registers, note select, peak capture, velocity divider.
// ----------------------------------------------------------------------------
module phmn_dp #(
  parameter int NOTE_COUNT = 17
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [phmn_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [phmn_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [phmn_pkg::SAMPLE_W-1:0]       sample_mv,
  input  logic                                up_press,
  input  logic                                down_press,
  input  phmn_pkg::ctrl_cmd_t                 cmd,
  output phmn_pkg::dp_stat_t                  stat,
  output logic [7:0]                          midi_byte
);
  import phmn_pkg::*;

  localparam int NW = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
  localparam logic [5:0] NC = 6'(NOTE_COUNT);

  logic [SAMPLE_W-1:0] threshold_mv, full_scale_mv;
  logic [VEL_W-1:0]    min_velocity, max_velocity;
  logic [WIN_W-1:0]    window_samples;

  logic [NW-1:0]       note_index;
  logic [SAMPLE_W-1:0] peak_level;
  logic [WIN_W-1:0]    window_count;
  logic [WIN_W-1:0]    count_inc;

  logic [5:0] ni_cur, ni_inc, ni_up, ni_down;

  // velocity path
  logic               flat;
  logic [11:0]        den;
  logic [18:0]        p1_c, p1;
  logic signed [12:0] d_c;
  logic signed [7:0]  k_c;
  logic signed [20:0] p2_c, p2;
  logic signed [21:0] t_c, t_neg;
  logic [20:0]        mag;
  logic [21:0]        num_c;
  logic               tneg;
  logic [12:0]        div_den;
  logic [13:0]        div_rem, rem_sh;
  logic [21:0]        div_quo;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic               q_bit;
  logic [21:0]        vq;
  logic [VEL_W-1:0]   velocity;
  logic [7:0]         note;

  assign count_inc        = window_count + WIN_W'(1);
  assign stat.trigger     = sample_mv > threshold_mv;
  assign stat.window_done = count_inc == window_samples;
  assign stat.div_last    = div_cnt == DIV_CNT_W'(DIV_STEPS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_mv   <= SAMPLE_W'(90);
      full_scale_mv  <= SAMPLE_W'(2000);
      min_velocity   <= VEL_W'(30);
      max_velocity   <= VEL_W'(127);
      window_samples <= WIN_W'(400);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_THRESHOLD:  threshold_mv   <= cfg_data;
        REG_FULL_SCALE: full_scale_mv  <= cfg_data;
        REG_MIN_VEL:    min_velocity   <= cfg_data[VEL_W-1:0];
        REG_MAX_VEL:    max_velocity   <= cfg_data[VEL_W-1:0];
        REG_WINDOW:     window_samples <= cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // up first, then down, each wrapping around the note list
  always_comb begin
    ni_cur  = 6'(note_index);
    ni_inc  = ni_cur + 6'd1;
    ni_up   = up_press ? ((ni_inc >= NC) ? 6'd0 : ni_inc) : ni_cur;
    ni_down = ni_up;
    if (down_press) begin
      ni_down = (ni_up == 6'd0 || ni_up >= NC) ? NC - 6'd1 : ni_up - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      note_index   <= '0;
      peak_level   <= '0;
      window_count <= '0;
    end else begin
      if (cmd.note_step) note_index <= ni_down[NW-1:0];
      if (cmd.start_cap) begin
        peak_level   <= '0;
        window_count <= '0;
      end else if (cmd.peak_step) begin
        if (sample_mv > peak_level) peak_level <= sample_mv;
        window_count <= count_inc;
      end
    end
  end

  // t = min*den + (peak - threshold)*(max - min)
  assign den  = full_scale_mv - threshold_mv;
  assign p1_c = {12'd0, min_velocity} * {7'd0, den};
  assign d_c  = $signed({1'b0, peak_level}) - $signed({1'b0, threshold_mv});
  assign k_c  = $signed({1'b0, max_velocity}) - $signed({1'b0, min_velocity});
  assign p2_c = d_c * k_c;

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      p1   <= p1_c;
      p2   <= p2_c;
      flat <= full_scale_mv <= threshold_mv;
    end
  end

  // round half away from zero: (2|t| + den) / (2 den)
  assign t_c   = $signed({3'b000, p1}) + $signed({p2[20], p2});
  assign t_neg = -t_c;
  assign mag   = t_c[21] ? t_neg[20:0] : t_c[20:0];
  assign num_c = {mag, 1'b0} + {10'd0, den};

  assign rem_sh = {div_rem[12:0], div_quo[21]};
  assign q_bit  = rem_sh >= {1'b0, div_den};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      tneg    <= t_c[21];
      div_den <= {den, 1'b0};
      div_rem <= '0;
      div_quo <= num_c;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_rem <= q_bit ? rem_sh - {1'b0, div_den} : rem_sh;
      div_quo <= {div_quo[20:0], q_bit};
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  // upper clamp first, lower clamp last
  always_comb begin
    vq = flat ? {15'd0, max_velocity} : (tneg ? 22'd0 : div_quo);
    if (vq > {15'd0, max_velocity}) vq = {15'd0, max_velocity};
    if (vq < {15'd0, min_velocity}) vq = {15'd0, min_velocity};
  end

  always_ff @(posedge clk) begin
    if (cmd.vel_latch) velocity <= vq[VEL_W-1:0];
  end

  assign note = note_lookup(5'(note_index));

  always_comb begin
    case (cmd.byte_sel)
      BYTE_STATUS_OFF: midi_byte = NOTE_ON_STATUS;
      BYTE_NOTE_OFF:   midi_byte = note;
      BYTE_VEL_OFF:    midi_byte = OFF_VELOCITY;
      BYTE_STATUS_ON:  midi_byte = NOTE_ON_STATUS;
      BYTE_NOTE_ON:    midi_byte = note;
      BYTE_VEL_ON:     midi_byte = {1'b0, velocity};
      default:         midi_byte = OFF_VELOCITY;
    endcase
  end

endmodule

FILE: hw/rtl/piezo_hit_to_midi_note.sv
// ----------------------------------------------------------------------------
// piezo_hit_to_midi_note
// Piezo drum trigger: peak capture over a window, velocity map, MIDI note-on.
// ----------------------------------------------------------------------------
// Samples are taken one beat per cycle while idle or capturing.
// The beat that closes a window starts the velocity computation: a multiply
// state and a load state, then the one-bit-per-cycle divider, then a clamp
// state; the first MIDI byte is valid in the send state that follows it.
// The six bytes then go out one per accepted beat; no sample is taken meanwhile.
// Synchronous reset restores register defaults, note index 0 and idle state.
module piezo_hit_to_midi_note #(
  parameter int NOTE_COUNT = 17
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [11:0] sample_mv, [12] up_press, [13] down_press
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] midi_byte
  output logic        m_tlast,   // last_byte
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [phmn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [phmn_pkg::CFG_DATA_W-1:0] cfg_data
);
  import phmn_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  phmn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .stat     (stat),
    .cmd      (cmd)
  );

  phmn_dp #(
    .NOTE_COUNT (NOTE_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_mv  (s_tdata[11:0]),
    .up_press   (s_tdata[12]),
    .down_press (s_tdata[13]),
    .cmd        (cmd),
    .stat       (stat),
    .midi_byte  (m_tdata)
  );

endmodule
